/* hdl/tsd_pkg.sv */
// Shared types and codes of the tag-serialised task dispatcher.
package tsd_pkg;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] KIND_MAIN    = 2'd0;
  localparam logic [1:0] KIND_BG      = 2'd1;
  localparam logic [1:0] KIND_TAGGED  = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADKIND = 2'd2;

  // Most results one drain may produce.
  localparam int MAX_RESULTS = 16;
  localparam int KW          = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic        became_ready;
    logic        got_task;
    logic [15:0] handle;
    logic [7:0]  tag;
    logic        last;
    logic [6:0]  ready_count;
    logic [1:0]  status;
  } res_t;

endpackage

/* hdl/tsd_core.sv */
// Dispatcher core: queue, tag table and pool memories with their sequencer.
module tsd_core #(
  parameter int READY_DEPTH = 64,
  parameter int MAIN_DEPTH  = 16,
  parameter int TAG_COUNT   = 256,
  parameter int POOL_DEPTH  = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_op,
  input  logic [1:0]      in_kind,
  input  logic [15:0]     in_handle,
  input  logic [7:0]      in_tag,
  input  logic [7:0]      in_ftag,
  output logic            res_valid,
  input  logic            res_ready,
  output tsd_pkg::res_t   res
);

  localparam int RAW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int RCW = $clog2(READY_DEPTH + 1);
  localparam int MAW = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
  localparam int MCW = $clog2(MAIN_DEPTH + 1);
  localparam int TW  = $clog2(TAG_COUNT);
  localparam int PW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int PCW = $clog2(POOL_DEPTH + 1);
  localparam int EW  = PCW + 2 * PW;
  localparam int HB  = HANDLE_BITS;
  localparam int KW  = tsd_pkg::KW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSHT = 3'd1;
  localparam logic [2:0] S_POPT  = 3'd2;
  localparam logic [2:0] S_POPP  = 3'd3;
  localparam logic [2:0] S_READY = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [RAW-1:0]       rd_head_r, rd_head_nxt, rd_tail_r, rd_tail_nxt;
  logic [RCW-1:0]       rd_fill_r, rd_fill_nxt;
  logic [MAW-1:0]       mn_head_r, mn_head_nxt, mn_tail_r, mn_tail_nxt;
  logic [MCW-1:0]       mn_fill_r, mn_fill_nxt;
  logic [PCW-1:0]       fresh_r, fresh_nxt, stk_cnt_r, stk_cnt_nxt;
  logic [TAG_COUNT-1:0] busy_r, busy_nxt;
  logic [KW-1:0]        drn_cnt_r, drn_cnt_nxt;
  logic                 res_valid_r, res_valid_nxt;
  tsd_pkg::res_t        res_r, res_nxt;
  logic [HB-1:0]        handle_r, handle_nxt;
  logic [TW-1:0]        key_r, key_nxt;

  logic [HB-1:0]  rd_h_mem [READY_DEPTH];
  logic [7:0]     rd_t_mem [READY_DEPTH];
  logic [HB-1:0]  mn_mem   [MAIN_DEPTH];
  logic [EW-1:0]  tg_mem   [TAG_COUNT];
  logic [HB-1:0]  pl_h_mem [POOL_DEPTH];
  logic [PW-1:0]  pl_n_mem [POOL_DEPTH];
  logic [PW-1:0]  stk_mem  [POOL_DEPTH];

  logic [HB-1:0] rd_h_q, mn_q, pl_h_q;
  logic [7:0]    rd_t_q;
  logic [EW-1:0] tg_q;
  logic [PW-1:0] pl_n_q, stk_q;

  logic          rd_we, rd_re, mn_we, mn_re, tg_we, tg_re, pl_hwe, pl_nwe, pl_re;
  logic          stk_we, stk_re;
  logic [HB-1:0] rd_wh;
  logic [7:0]    rd_wt;
  logic [EW-1:0] tg_wd;
  logic [TW-1:0] tg_ra, tg_wa;
  logic [PW-1:0] pl_hwa, pl_nwa, pl_nwd, pl_ra, stk_wa, stk_wd, slot;

  logic [TW-1:0] tag_lut [256];
  logic [TW-1:0] tidx, fidx;
  logic [1:0]    ekind;
  logic [PCW-1:0] tq_fill;
  logic [PW-1:0]  tq_head, tq_tail;
  logic          slot_free, accept, emit, do_rphase, pend, e_last, e_br, e_got;
  logic [15:0]   e_handle;
  logic [7:0]    e_tag;
  logic [1:0]    e_status;

  function automatic logic [RAW-1:0] rd_inc(input logic [RAW-1:0] p);
    return (p == RAW'(READY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [MAW-1:0] mn_inc(input logic [MAW-1:0] p);
    return (p == MAW'(MAIN_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    for (int i = 0; i < 256; i++) begin
      tag_lut[i] = TW'(i % TAG_COUNT);
    end
  end

  assign tidx      = tag_lut[in_tag];
  assign fidx      = tag_lut[in_ftag];
  assign tq_fill   = tg_q[EW-1 -: PCW];
  assign tq_head   = tg_q[2*PW-1 -: PW];
  assign tq_tail   = tg_q[PW-1:0];
  assign slot_free = !res_valid_r || res_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign slot      = (stk_cnt_r != '0) ? stk_q : PW'(fresh_r);
  assign ekind     = (in_kind == tsd_pkg::KIND_TAGGED && tidx == '0) ? tsd_pkg::KIND_BG
                                                                       : in_kind;

  always_comb begin
    state_nxt   = state_r;
    rd_head_nxt = rd_head_r;
    rd_tail_nxt = rd_tail_r;
    rd_fill_nxt = rd_fill_r;
    mn_head_nxt = mn_head_r;
    mn_tail_nxt = mn_tail_r;
    mn_fill_nxt = mn_fill_r;
    fresh_nxt   = fresh_r;
    stk_cnt_nxt = stk_cnt_r;
    busy_nxt    = busy_r;
    drn_cnt_nxt = drn_cnt_r;
    handle_nxt  = handle_r;
    key_nxt     = key_r;
    rd_we = 1'b0; rd_re = 1'b0; rd_wh = handle_r; rd_wt = 8'(key_r);
    mn_we = 1'b0; mn_re = 1'b0;
    tg_we = 1'b0; tg_re = 1'b0; tg_wd = tg_q; tg_ra = key_r; tg_wa = key_r;
    pl_hwe = 1'b0; pl_nwe = 1'b0; pl_re = 1'b0;
    pl_hwa = slot; pl_nwa = tq_tail; pl_nwd = slot; pl_ra = tq_head;
    stk_we = 1'b0; stk_re = 1'b0; stk_wa = PW'(stk_cnt_r); stk_wd = tq_head;
    emit = 1'b0; e_br = 1'b0; e_got = 1'b0; e_handle = '0; e_tag = '0;
    e_last = 1'b1; e_status = tsd_pkg::ST_OK;
    do_rphase = 1'b0; pend = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          handle_nxt = HB'(in_handle);
          case (in_op)
            tsd_pkg::OP_PUSH: begin
              key_nxt = tidx;
              case (ekind) inside
                tsd_pkg::KIND_MAIN: begin
                  emit = 1'b1;
                  if (mn_fill_r == MCW'(MAIN_DEPTH)) begin
                    e_status = tsd_pkg::ST_FULL;
                  end else begin
                    mn_we       = 1'b1;
                    mn_tail_nxt = mn_inc(mn_tail_r);
                    mn_fill_nxt = mn_fill_r + 1'b1;
                  end
                end
                tsd_pkg::KIND_BG, tsd_pkg::KIND_TAGGED: begin
                  if (ekind == tsd_pkg::KIND_TAGGED && busy_r[tidx]) begin
                    if (fresh_r == PCW'(POOL_DEPTH) && stk_cnt_r == '0) begin
                      emit     = 1'b1;
                      e_status = tsd_pkg::ST_FULL;
                    end else begin
                      tg_re     = 1'b1;
                      tg_ra     = tidx;
                      stk_re    = (stk_cnt_r != '0);
                      state_nxt = S_PUSHT;
                    end
                  end else begin
                    emit = 1'b1;
                    if (rd_fill_r == RCW'(READY_DEPTH)) begin
                      e_status = tsd_pkg::ST_FULL;
                    end else begin
                      rd_we       = 1'b1;
                      rd_wh       = HB'(in_handle);
                      rd_wt       = (ekind == tsd_pkg::KIND_TAGGED) ? 8'(tidx) : 8'd0;
                      rd_tail_nxt = rd_inc(rd_tail_r);
                      rd_fill_nxt = rd_fill_r + 1'b1;
                      e_br        = 1'b1;
                      if (ekind == tsd_pkg::KIND_TAGGED) begin
                        // Start the tag with an empty waiting list.
                        busy_nxt[tidx] = 1'b1;
                        tg_we          = 1'b1;
                        tg_wa          = tidx;
                        tg_wd          = '0;
                      end
                    end
                  end
                end
                default: begin
                  emit     = 1'b1;
                  e_status = tsd_pkg::ST_BADKIND;
                end
              endcase
            end
            tsd_pkg::OP_POP: begin
              key_nxt = fidx;
              if (fidx != '0 && busy_r[fidx]) begin
                tg_re     = 1'b1;
                tg_ra     = fidx;
                state_nxt = S_POPT;
              end else begin
                do_rphase = 1'b1;
              end
            end
            tsd_pkg::OP_DRAIN: begin
              if (mn_fill_r == '0) begin
                emit = 1'b1;
              end else begin
                mn_re       = 1'b1;
                mn_head_nxt = mn_inc(mn_head_r);
                mn_fill_nxt = mn_fill_r - 1'b1;
                drn_cnt_nxt = KW'(1);
                state_nxt   = S_DRAIN;
              end
            end
            default: begin
              rd_head_nxt = '0;
              rd_tail_nxt = '0;
              rd_fill_nxt = '0;
              emit        = 1'b1;
            end
          endcase
        end
      end
      S_PUSHT: begin
        pl_hwe = 1'b1;
        pl_nwe = (tq_fill != '0);
        tg_we  = 1'b1;
        tg_wd  = {tq_fill + 1'b1, (tq_fill == '0) ? slot : tq_head, slot};
        if (stk_cnt_r != '0) begin
          stk_cnt_nxt = stk_cnt_r - 1'b1;
        end else begin
          fresh_nxt = fresh_r + 1'b1;
        end
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_POPT: begin
        if (tq_fill == '0) begin
          busy_nxt[key_r] = 1'b0;
          do_rphase       = 1'b1;
        end else begin
          pl_re     = 1'b1;
          state_nxt = S_POPP;
        end
      end
      S_POPP: begin
        tg_we       = 1'b1;
        tg_wd       = {tq_fill - 1'b1, pl_n_q, tq_tail};
        stk_we      = 1'b1;
        stk_cnt_nxt = stk_cnt_r + 1'b1;
        pend        = 1'b1;
        do_rphase   = 1'b1;
      end
      S_READY: begin
        emit      = 1'b1;
        e_got     = 1'b1;
        e_handle  = 16'(rd_h_q);
        e_tag     = rd_t_q;
        state_nxt = S_IDLE;
      end
      S_DRAIN: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_got    = 1'b1;
          e_handle = 16'(mn_q);
          e_last   = (mn_fill_r == '0) || (drn_cnt_r == KW'(tsd_pkg::MAX_RESULTS));
          if (e_last) begin
            state_nxt = S_IDLE;
          end else begin
            mn_re       = 1'b1;
            mn_head_nxt = mn_inc(mn_head_r);
            mn_fill_nxt = mn_fill_r - 1'b1;
            drn_cnt_nxt = drn_cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Release then dequeue; a release into an empty queue hands straight back.
    if (do_rphase) begin
      state_nxt = S_IDLE;
      if (pend && rd_fill_r == '0) begin
        emit        = 1'b1;
        e_got       = 1'b1;
        e_handle    = 16'(pl_h_q);
        e_tag       = 8'(key_r);
        rd_head_nxt = rd_inc(rd_head_r);
        rd_tail_nxt = rd_inc(rd_tail_r);
      end else if (pend) begin
        rd_we       = 1'b1;
        rd_wh       = pl_h_q;
        rd_tail_nxt = rd_inc(rd_tail_r);
        rd_re       = 1'b1;
        rd_head_nxt = rd_inc(rd_head_r);
        state_nxt   = S_READY;
      end else if (rd_fill_r != '0) begin
        rd_re       = 1'b1;
        rd_head_nxt = rd_inc(rd_head_r);
        rd_fill_nxt = rd_fill_r - 1'b1;
        state_nxt   = S_READY;
      end else begin
        emit = 1'b1;
      end
    end

    res_valid_nxt = emit || (res_valid_r && !res_ready);
    res_nxt       = res_r;
    if (emit) begin
      res_nxt.became_ready = e_br;
      res_nxt.got_task     = e_got;
      res_nxt.handle       = e_handle;
      res_nxt.tag          = e_tag;
      res_nxt.last         = e_last;
      res_nxt.ready_count  = 7'(rd_fill_nxt);
      res_nxt.status       = e_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_head_r   <= '0;
      rd_tail_r   <= '0;
      rd_fill_r   <= '0;
      mn_head_r   <= '0;
      mn_tail_r   <= '0;
      mn_fill_r   <= '0;
      fresh_r     <= '0;
      stk_cnt_r   <= '0;
      busy_r      <= '0;
      drn_cnt_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_head_r   <= rd_head_nxt;
      rd_tail_r   <= rd_tail_nxt;
      rd_fill_r   <= rd_fill_nxt;
      mn_head_r   <= mn_head_nxt;
      mn_tail_r   <= mn_tail_nxt;
      mn_fill_r   <= mn_fill_nxt;
      fresh_r     <= fresh_nxt;
      stk_cnt_r   <= stk_cnt_nxt;
      busy_r      <= busy_nxt;
      drn_cnt_r   <= drn_cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    handle_r <= handle_nxt;
    key_r    <= key_nxt;
  end

  // Memories: one write and one registered read a cycle each.
  always_ff @(posedge clk) begin
    if (rd_we) begin
      rd_h_mem[rd_tail_r] <= rd_wh;
      rd_t_mem[rd_tail_r] <= rd_wt;
    end
    if (rd_re) begin
      rd_h_q <= rd_h_mem[rd_head_r];
      rd_t_q <= rd_t_mem[rd_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (mn_we) begin
      mn_mem[mn_tail_r] <= handle_nxt;
    end
    if (mn_re) begin
      mn_q <= mn_mem[mn_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (tg_we) begin
      tg_mem[tg_wa] <= tg_wd;
    end
    if (tg_re) begin
      tg_q <= tg_mem[tg_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pl_hwe) begin
      pl_h_mem[pl_hwa] <= handle_r;
    end
    if (pl_nwe) begin
      pl_n_mem[pl_nwa] <= pl_nwd;
    end
    if (pl_re) begin
      pl_h_q <= pl_h_mem[pl_ra];
      pl_n_q <= pl_n_mem[pl_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_q <= stk_mem[PW'(stk_cnt_r - 1'b1)];
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

/* hdl/tsd_out.sv */
// Output register: holds one result beat and packs it onto the stream.
module tsd_out (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  output logic          res_ready,
  input  tsd_pkg::res_t res,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [39:0]   out_tdata,
  output logic          out_tlast
);

  logic          vld_r, vld_nxt;
  tsd_pkg::res_t beat_r;

  assign res_ready = !vld_r || out_tready;
  assign vld_nxt   = res_valid || (vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      beat_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tlast  = beat_r.last;
  assign out_tdata  = {5'd0, beat_r.status, beat_r.ready_count, beat_r.tag,
                       beat_r.handle, beat_r.got_task, beat_r.became_ready};

endmodule

/* hdl/tag_serialized_task_dispatcher.sv */
// Top level of the tag-serialised task dispatcher.
// Each input beat carries one command and yields result beats on the output
// stream: one for push, pop and clear, and up to sixteen for a drain of the
// main queue, the final one flagged by out_tlast. Main, background and invalid
// pushes, clears, pushes dropped for lack of a pool slot and pops that find
// nothing to release and an empty ready queue finish in the idle state. A pop
// with nothing to release that dequeues a ready task reads the ready queue
// first. A push to a busy tag reads the tag table and free slot, then updates
// the linked list. A pop that releases a tag reads the tag table, then as
// needed the pool and the ready queue. A drain reads the main queue through
// the single read port of its memory, fetching the next task while it delivers
// the current one. The next command is taken once the previous one has
// produced all its beats into the output register; one finished beat may wait
// there while the next command runs, and a stalled receiver holds the next
// command back. No clearing pass is needed after reset: tag busy flags live in
// flip-flops, a tag's waiting-list entry is written empty when the tag turns
// busy, and every other memory entry is written before its contents are used.
module tag_serialized_task_dispatcher #(
  parameter int READY_DEPTH = 64,
  parameter int MAIN_DEPTH  = 16,
  parameter int TAG_COUNT   = 256,
  parameter int POOL_DEPTH  = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // task_handle[15:0], tag[23:16], finished_tag[31:24]
  input  logic [3:0]  in_tuser,   // operation[1:0], kind[3:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // became_ready[0], got_task[1], out_handle[17:2],
                                  // out_tag[25:18], ready_count[32:26], status[34:33]
  output logic        out_tlast
);

  logic          res_valid, res_ready;
  tsd_pkg::res_t res;

  tsd_core #(
    .READY_DEPTH (READY_DEPTH),
    .MAIN_DEPTH  (MAIN_DEPTH),
    .TAG_COUNT   (TAG_COUNT),
    .POOL_DEPTH  (POOL_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser[1:0]),
    .in_kind   (in_tuser[3:2]),
    .in_handle (in_tdata[15:0]),
    .in_tag    (in_tdata[23:16]),
    .in_ftag   (in_tdata[31:24]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  tsd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* hdl/tsd_checker.sv */
// Port-level checks of the dispatcher, bound to the top level.
module tsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // Hold a stalled beat.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result beat changed");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("beat both readies and delivers");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:33] != tsd_pkg::ST_OK |-> !out_tdata[0] && !out_tdata[1])
    else $error("failed push reports a task");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[25:2] == 24'd0)
    else $error("empty result carries a handle or tag");

  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_tready, out_tvalid}))
    else $error("handshake output unknown");

endmodule

bind tag_serialized_task_dispatcher tsd_checker u_chk (.*);
